[hw/rtl/cjm_pkg.sv]
`timescale 1ns / 1ps
package cjm_pkg;

	localparam int CJM_MAX_CONST = 64;

	localparam int TOL_W       = 10;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 10;
	localparam int IN_TDATA_W  = 184;
	localparam int IN_TUSER_W  = 3;
	localparam int OUT_TDATA_W = 256;
	localparam int OUT_TUSER_W = 2;
	localparam int MOM_W       = 32;
	localparam int MOM_LSB     = 54;

	localparam logic [CFG_IDX_W-1:0] CFG_TOL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REQ = 1'd1;

	localparam logic [TOL_W-1:0] TOL_RESET = 10'd31;

	typedef enum logic [1:0] {
		FN_START,
		FN_ADD,
		FN_DAUGHTER,
		FN_END
	} func_t;

	typedef struct packed {
		logic        tag;
		logic [22:0] pt;
		logic [12:0] phi;
		logic [14:0] eta;
		logic [2:0]  charge;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic done;
		logic matched;
		logic tag;
	} srch_res_t;

endpackage

[hw/rtl/cjm_store.sv]
`timescale 1ns / 1ps
module cjm_store #(
	parameter int MAX_CONSTITUENTS = cjm_pkg::CJM_MAX_CONST,
	parameter int AW = (MAX_CONSTITUENTS > 1) ? $clog2(MAX_CONSTITUENTS) : 1
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  cjm_pkg::entry_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output cjm_pkg::entry_t rdata
);
	import cjm_pkg::*;

	logic [ENTRY_W-1:0] mem [MAX_CONSTITUENTS];
	logic [ENTRY_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = entry_t'(rdata_q);

endmodule

[hw/rtl/cjm_search.sv]
`timescale 1ns / 1ps
module cjm_search #(
	parameter int MAX_CONSTITUENTS = cjm_pkg::CJM_MAX_CONST,
	parameter int AW = (MAX_CONSTITUENTS > 1) ? $clog2(MAX_CONSTITUENTS) : 1,
	parameter int CW = $clog2(MAX_CONSTITUENTS + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  cjm_pkg::entry_t         key,
	input  logic [CW-1:0]           count,
	input  logic [cjm_pkg::TOL_W-1:0] tol,
	output logic                    rd_en,
	output logic [AW-1:0]           rd_addr,
	input  cjm_pkg::entry_t         rd_data,
	output logic                    busy,
	output cjm_pkg::srch_res_t      res
);
	import cjm_pkg::*;

	logic          busy_q;
	logic [CW-1:0] rd_idx_q;
	logic          rvalid_s1;
	logic          last_s1;
	entry_t        key_q;
	logic          hit;
	logic          stop;

	function automatic logic near(input logic signed [24:0] a, input logic signed [24:0] b,
			input logic [TOL_W-1:0] t);
		logic signed [25:0] d;
		logic [25:0] m;
		d = {a[24], a} - {b[24], b};
		m = d[25] ? 26'(-d) : 26'(d);
		return m <= {{(26 - TOL_W){1'b0}}, t};
	endfunction

	always_comb begin
		hit = rvalid_s1 && (rd_data.charge == key_q.charge)
			&& near(25'(signed'(rd_data.eta)), 25'(signed'(key_q.eta)), tol)
			&& near(25'(signed'(rd_data.phi)), 25'(signed'(key_q.phi)), tol)
			&& near({2'b00, rd_data.pt}, {2'b00, key_q.pt}, tol);
		stop = hit || (rvalid_s1 && last_s1);
		rd_en = busy_q && !stop && (rd_idx_q < count);
		rd_addr = rd_idx_q[AW-1:0];
		res.done = stop;
		res.matched = hit;
		res.tag = rd_data.tag;
	end

	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rd_idx_q <= '0;
			rvalid_s1 <= 1'b0;
			last_s1 <= 1'b0;
			key_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			rd_idx_q <= '0;
			rvalid_s1 <= 1'b0;
			last_s1 <= 1'b0;
			key_q <= key;
		end else if (busy_q) begin
			if (stop) begin
				busy_q <= 1'b0;
				rvalid_s1 <= 1'b0;
			end else begin
				rvalid_s1 <= rd_en;
				last_s1 <= (rd_idx_q + CW'(1)) == count;
				rd_idx_q <= rd_idx_q + CW'(rd_en);
			end
		end
	end

endmodule

[hw/rtl/jet_constituent_match_correct_unit.sv]
`timescale 1ns / 1ps
// Jet constituent matcher with momentum correction. A start-jet, add-constituent or
// end-candidate transfer is handled in the idle state; a daughter reads the stored
// constituents one store read per cycle through the single read port of the constituent
// store, the search stops at the first match, and a daughter without a match then goes
// on to the saturating add. No input transfer is taken while an earlier result is still
// held at the output and not taken. Write the configuration only while idle.
module jet_constituent_match_correct_unit #(
	parameter int MAX_CONSTITUENTS = cjm_pkg::CJM_MAX_CONST
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// charge, eta, phi, pt, px, py, pz, energy, zero pad
	input  logic [cjm_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
	// func, muon_tag
	input  logic [cjm_pkg::IN_TUSER_W-1:0]       s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// jet_px, jet_py, jet_pz, jet_energy, adj_px, adj_py, adj_pz, adj_energy
	output logic [cjm_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	// dimuon_included, overflow
	output logic [cjm_pkg::OUT_TUSER_W-1:0]      m_axis_tuser,
	input  logic                                 cfg_we,
	input  logic [cjm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [cjm_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
	import cjm_pkg::*;

	localparam int AW = (MAX_CONSTITUENTS > 1) ? $clog2(MAX_CONSTITUENTS) : 1;
	localparam int CW = $clog2(MAX_CONSTITUENTS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_ADD
	} state_t;

	state_t             state_q;
	logic [TOL_W-1:0]   tol_q;
	logic               req_q;
	logic [CW-1:0]      cnt_q;
	logic               dropped_q;
	logic               dim_q;
	logic               ovf_q;
	logic [MOM_W-1:0]   jet_q [4];
	logic [MOM_W-1:0]   acc_q [4];
	logic [MOM_W-1:0]   dmom_q [4];
	logic               out_valid_q;
	logic [MOM_W-1:0]   out_jet_q [4];
	logic [MOM_W-1:0]   out_adj_q [4];
	logic               out_dim_q;
	logic               out_ovf_q;

	logic               s_fire;
	func_t              func;
	entry_t             in_entry;
	logic [MOM_W-1:0]   in_mom [4];
	logic               store_we;
	logic               srch_start;
	logic               srch_busy;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	entry_t             rd_data;
	srch_res_t          srch_res;
	logic               end_emit;
	logic [MOM_W-1:0]   sat_sum [4];
	logic [3:0]         sat_hit;
	logic [MOM_W:0]     wide_sum;

	always_comb begin
		func = func_t'(s_axis_tuser[1:0]);
		in_entry.charge = s_axis_tdata[2:0];
		in_entry.eta = s_axis_tdata[17:3];
		in_entry.phi = s_axis_tdata[30:18];
		in_entry.pt = s_axis_tdata[53:31];
		in_entry.tag = s_axis_tuser[2];
		for (int k = 0; k < 4; k++) begin
			in_mom[k] = s_axis_tdata[MOM_LSB + MOM_W * k +: MOM_W];
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
	assign s_fire = s_axis_tvalid && s_axis_tready;
	assign store_we = s_fire && (func == FN_ADD) && (cnt_q < CW'(MAX_CONSTITUENTS));
	assign srch_start = s_fire && (func == FN_DAUGHTER) && (cnt_q != '0);
	assign end_emit = s_fire && (func == FN_END) && (!req_q || dim_q);

	always_comb begin
		wide_sum = '0;
		for (int k = 0; k < 4; k++) begin
			wide_sum = {acc_q[k][MOM_W-1], acc_q[k]} + {dmom_q[k][MOM_W-1], dmom_q[k]};
			sat_hit[k] = wide_sum[MOM_W] != wide_sum[MOM_W-1];
			if (sat_hit[k]) begin
				sat_sum[k] = wide_sum[MOM_W] ? {1'b1, {(MOM_W - 1){1'b0}}}
					: {1'b0, {(MOM_W - 1){1'b1}}};
			end else begin
				sat_sum[k] = wide_sum[MOM_W-1:0];
			end
		end
	end

	cjm_store #(
		.MAX_CONSTITUENTS(MAX_CONSTITUENTS),
		.AW(AW)
	) u_store (
		.clk(clk),
		.we(store_we),
		.waddr(cnt_q[AW-1:0]),
		.wdata(in_entry),
		.re(rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	cjm_search #(
		.MAX_CONSTITUENTS(MAX_CONSTITUENTS),
		.AW(AW),
		.CW(CW)
	) u_search (
		.clk(clk),
		.arst_n(arst_n),
		.start(srch_start),
		.key(in_entry),
		.count(cnt_q),
		.tol(tol_q),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.busy(srch_busy),
		.res(srch_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
			req_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TOL: tol_q <= cfg_wdata[TOL_W-1:0];
				CFG_REQ: req_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			dropped_q <= 1'b0;
			dim_q <= 1'b0;
			ovf_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_dim_q <= 1'b0;
			out_ovf_q <= 1'b0;
			for (int k = 0; k < 4; k++) begin
				jet_q[k] <= '0;
				acc_q[k] <= '0;
				dmom_q[k] <= '0;
				out_jet_q[k] <= '0;
				out_adj_q[k] <= '0;
			end
		end else begin
			if (end_emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						unique case (func)
							FN_START: begin
								cnt_q <= '0;
								dropped_q <= 1'b0;
								dim_q <= 1'b0;
								ovf_q <= 1'b0;
								for (int k = 0; k < 4; k++) begin
									jet_q[k] <= in_mom[k];
									acc_q[k] <= in_mom[k];
								end
							end
							FN_ADD: begin
								if (store_we) begin
									cnt_q <= cnt_q + CW'(1);
								end else begin
									dropped_q <= 1'b1;
								end
							end
							FN_DAUGHTER: begin
								for (int k = 0; k < 4; k++) begin
									dmom_q[k] <= in_mom[k];
								end
								state_q <= (cnt_q == '0) ? ST_ADD : ST_SEARCH;
							end
							FN_END: begin
								if (end_emit) begin
									out_dim_q <= dim_q;
									out_ovf_q <= ovf_q || dropped_q;
									for (int k = 0; k < 4; k++) begin
										out_jet_q[k] <= jet_q[k];
										out_adj_q[k] <= acc_q[k];
									end
								end
								dim_q <= 1'b0;
								ovf_q <= 1'b0;
								for (int k = 0; k < 4; k++) begin
									acc_q[k] <= jet_q[k];
								end
							end
							default: ;
						endcase
					end
				end
				ST_SEARCH: begin
					if (srch_res.done) begin
						if (srch_res.matched) begin
							dim_q <= dim_q || srch_res.tag;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_ADD;
						end
					end
				end
				ST_ADD: begin
					for (int k = 0; k < 4; k++) begin
						acc_q[k] <= sat_sum[k];
					end
					ovf_q <= ovf_q || (sat_hit != '0);
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {out_adj_q[3], out_adj_q[2], out_adj_q[1], out_adj_q[0],
		out_jet_q[3], out_jet_q[2], out_jet_q[1], out_jet_q[0]};
	assign m_axis_tuser = {out_ovf_q, out_dim_q};

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_CONSTITUENTS))
		else $error("constituent count beyond store depth");

	a_done_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		srch_res.done |-> (state_q == ST_SEARCH))
		else $error("search result outside search state");

	a_no_write_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		store_we |-> !srch_busy)
		else $error("store write during search");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		end_emit |=> m_axis_tvalid)
		else $error("end of candidate lost its result");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
	import cjm_pkg::*;

	typedef logic [3:0][MOM_W-1:0] mom_t;

	typedef struct packed {
		func_t              func;
		logic signed [2:0]  charge;
		logic signed [14:0] eta;
		logic signed [12:0] phi;
		logic [22:0]        pt;
		mom_t               mom;
		logic               tag;
	} in_item_t;

	typedef struct packed {
		mom_t jet;
		mom_t adj;
		logic dimuon;
		logic ovf;
	} cand_res_t;

	typedef struct {
		bit                   is_cfg;
		logic [CFG_IDX_W-1:0] reg_idx;
		int                   reg_val;
		in_item_t             it;
		int                   reps;
		bit                   has_want;
		cand_res_t            want;
	} dir_row_t;

	localparam int HOLD_CYCLES = CJM_MAX_CONST + 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int MOM_MAX     = 32'h7fffffff;
	localparam int MOM_MIN     = 32'h80000000;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [OUT_TUSER_W-1:0] m_axis_tuser;
	logic                   cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index     = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata     = '0;

	jet_constituent_match_correct_unit u_dut (.*);

	always #5 clk = ~clk;

	// model of the matcher
	entry_t    jet_store [CJM_MAX_CONST];
	int        n_stored        = 0;
	bit        store_full_drop = 1'b0;
	mom_t      jet_mom         = '0;
	mom_t      adj_mom         = '0;
	bit        dimuon_seen     = 1'b0;
	bit        sum_saturated   = 1'b0;
	int        match_tol       = TOL_RESET;
	bit        need_dimuon     = 1'b0;

	cand_res_t cand_queue [$];
	dir_row_t  dir_rows [$];
	int        mismatches = 0;
	int        cycles     = 0;
	bit        quiet      = 1'b0;
	string     mom_names [4] = '{"px", "py", "pz", "energy"};

	function automatic bit close_enough(input longint a, input longint b);
		longint d;
		d = a - b;
		if (d < 0)
			d = -d;
		return d <= match_tol;
	endfunction

	function automatic bit predict_jet_step(input in_item_t it, output cand_res_t r);
		longint s;
		bit     hit;
		bit     emit;
		r    = '0;
		hit  = 1'b0;
		emit = 1'b0;
		case (it.func)
			FN_START: begin
				jet_mom         = it.mom;
				adj_mom         = it.mom;
				n_stored        = 0;
				store_full_drop = 1'b0;
				dimuon_seen     = 1'b0;
				sum_saturated   = 1'b0;
			end
			FN_ADD: begin
				if (n_stored < CJM_MAX_CONST) begin
					jet_store[n_stored].charge = it.charge;
					jet_store[n_stored].eta    = it.eta;
					jet_store[n_stored].phi    = it.phi;
					jet_store[n_stored].pt     = it.pt;
					jet_store[n_stored].tag    = it.tag;
					n_stored++;
				end else begin
					store_full_drop = 1'b1;
				end
			end
			FN_DAUGHTER: begin
				for (int i = 0; i < n_stored && !hit; i++) begin
					if (jet_store[i].charge == it.charge &&
					    close_enough($signed(jet_store[i].eta), it.eta) &&
					    close_enough($signed(jet_store[i].phi), it.phi) &&
					    close_enough(jet_store[i].pt, it.pt)) begin
						hit = 1'b1;
						if (jet_store[i].tag)
							dimuon_seen = 1'b1;
					end
				end
				if (!hit) begin
					for (int k = 0; k < 4; k++) begin
						s = longint'($signed(adj_mom[k])) + longint'($signed(it.mom[k]));
						if (s > 64'sd2147483647) begin
							adj_mom[k]    = 32'h7fffffff;
							sum_saturated = 1'b1;
						end else if (s < -64'sd2147483648) begin
							adj_mom[k]    = 32'h80000000;
							sum_saturated = 1'b1;
						end else begin
							adj_mom[k] = s[31:0];
						end
					end
				end
			end
			default: begin
				if (!need_dimuon || dimuon_seen) begin
					r.jet    = jet_mom;
					r.adj    = adj_mom;
					r.dimuon = dimuon_seen;
					r.ovf    = sum_saturated || store_full_drop;
					emit     = 1'b1;
				end
				adj_mom       = jet_mom;
				dimuon_seen   = 1'b0;
				sum_saturated = 1'b0;
			end
		endcase
		return emit;
	endfunction

	function automatic int rnd_range(input int lo, input int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	function automatic int clamp(input int v, input int lo, input int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic mom_t mom4(input int x, input int y, input int z, input int e);
		return {e, z, y, x};
	endfunction

	function automatic in_item_t rnd_item(input func_t f);
		in_item_t it;
		int       mode;
		mode      = $urandom_range(7);
		it.func   = f;
		it.charge = 3'(rnd_range(-2, 2));
		it.eta    = 15'(rnd_range(-8192, 8192));
		it.phi    = 13'(rnd_range(-3217, 3217));
		it.pt     = $urandom_range(1) ? 23'($urandom_range(8388607)) : 23'($urandom_range(4095));
		for (int k = 0; k < 4; k++) begin
			case (mode)
				0:       it.mom[k] = $urandom;
				1:       it.mom[k] = $urandom_range(1) ? MOM_MAX : MOM_MIN;
				default: it.mom[k] = 32'(rnd_range(-1048576, 1048576));
			endcase
		end
		it.tag = 1'($urandom_range(1));
		return it;
	endfunction

	function automatic in_item_t near_copy(input in_item_t src);
		in_item_t it;
		int       w;
		it = rnd_item(FN_DAUGHTER);
		w  = match_tol + 2;
		if ($urandom_range(9) != 0)
			it.charge = src.charge;
		it.eta = 15'(clamp(int'(src.eta) + rnd_range(-w, w), -8192, 8192));
		it.phi = 13'(clamp(int'(src.phi) + rnd_range(-w, w), -3217, 3217));
		it.pt  = 23'(clamp(int'(src.pt) + rnd_range(-w, w), 0, 8388607));
		return it;
	endfunction

	function automatic dir_row_t item_row(input func_t f, input int ch, input int eta,
	                                      input int phi, input int pt, input mom_t m,
	                                      input bit tag);
		dir_row_t rw;
		rw           = '{default: '0};
		rw.it.func   = f;
		rw.it.charge = 3'(ch);
		rw.it.eta    = 15'(eta);
		rw.it.phi    = 13'(phi);
		rw.it.pt     = 23'(pt);
		rw.it.mom    = m;
		rw.it.tag    = tag;
		rw.reps      = 1;
		return rw;
	endfunction

	function automatic dir_row_t end_row(input mom_t j, input mom_t a, input bit dm,
	                                     input bit ov);
		dir_row_t rw;
		rw             = item_row(FN_END, 0, 0, 0, 0, '0, 1'b0);
		rw.has_want    = 1'b1;
		rw.want.jet    = j;
		rw.want.adj    = a;
		rw.want.dimuon = dm;
		rw.want.ovf    = ov;
		return rw;
	endfunction

	function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
		dir_row_t rw;
		rw         = '{default: '0};
		rw.is_cfg  = 1'b1;
		rw.reg_idx = idx;
		rw.reg_val = val;
		return rw;
	endfunction

	function automatic void add_row(input dir_row_t rw);
		dir_rows = {dir_rows, rw};
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("ERROR @%0t: %s", $time, msg);
	endtask

	task automatic transfer_item(input in_item_t it, output bit got, output cand_res_t r);
		if (!quiet && $urandom_range(99) < 12) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_axis_tdata  <= {2'b00, it.mom, it.pt, it.phi, it.eta, it.charge};
		s_axis_tuser  <= {it.tag, it.func};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		got = predict_jet_step(it, r);
	endtask

	task automatic push_item(input in_item_t it);
		bit        got;
		cand_res_t r;
		transfer_item(it, got, r);
		if (got)
			cand_queue = {cand_queue, r};
	endtask

	// hold the sender until every candidate is out and the last search has finished
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (cand_queue.size() != 0)
			@(posedge clk);
		repeat (HOLD_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_DATA_W'(val);
		@(posedge clk);
		if (idx == CFG_TOL)
			match_tol = val;
		else
			need_dimuon = (val & 1) != 0;
	endtask

	task automatic run_jets(input int n_items);
		in_item_t kept [$];
		in_item_t it;
		int       sent;
		int       n_add;
		int       n_cand;
		int       n_dau;
		bit       broke;
		sent = 0;
		while (sent < n_items) begin
			push_item(rnd_item(FN_START));
			sent++;
			case ($urandom_range(19))
				0:       n_add = $urandom_range(CJM_MAX_CONST - 4, CJM_MAX_CONST + 2);
				1, 2, 3: n_add = $urandom_range(9, 40);
				default: n_add = $urandom_range(0, 8);
			endcase
			kept.delete();
			repeat (n_add) begin
				it = rnd_item(FN_ADD);
				push_item(it);
				kept = {kept, it};
				sent++;
			end
			n_cand = $urandom_range(1, 4);
			broke  = 1'b0;
			for (int c = 0; c < n_cand && !broke; c++) begin
				n_dau = $urandom_range(0, 5);
				repeat (n_dau) begin
					if (kept.size() != 0 && $urandom_range(2) != 0)
						it = near_copy(kept[$urandom_range(kept.size() - 1)]);
					else
						it = rnd_item(FN_DAUGHTER);
					push_item(it);
					sent++;
					if ($urandom_range(24) == 0) begin
						push_item(rnd_item(func_t'($urandom_range(3))));
						sent++;
					end
				end
				if ($urandom_range(19) == 0) begin
					broke = 1'b1;
				end else begin
					push_item(rnd_item(FN_END));
					sent++;
				end
			end
		end
	endtask

	always @(posedge clk) begin
		m_axis_tready <= quiet || ($urandom_range(99) >= 12);
	end

	always @(posedge clk) begin
		cand_res_t got;
		cand_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.jet    = m_axis_tdata[127:0];
			got.adj    = m_axis_tdata[255:128];
			got.dimuon = m_axis_tuser[0];
			got.ovf    = m_axis_tuser[1];
			if (cand_queue.size() == 0) begin
				report_mismatch("candidate transfer with none awaited");
			end else begin
				want = cand_queue.pop_front();
				for (int k = 0; k < 4; k++) begin
					if (got.jet[k] !== want.jet[k])
						report_mismatch($sformatf("jet_%s got %0d expected %0d", mom_names[k],
							$signed(got.jet[k]), $signed(want.jet[k])));
					if (got.adj[k] !== want.adj[k])
						report_mismatch($sformatf("adj_%s got %0d expected %0d", mom_names[k],
							$signed(got.adj[k]), $signed(want.adj[k])));
				end
				if (got.dimuon !== want.dimuon)
					report_mismatch($sformatf("dimuon_included got %b expected %b",
						got.dimuon, want.dimuon));
				if (got.ovf !== want.ovf)
					report_mismatch($sformatf("overflow got %b expected %b", got.ovf, want.ovf));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		dir_row_t  rw;
		bit        got;
		cand_res_t r;
		int        ph_tol [5];
		bit        ph_req [5];
		int        ph_len [5];
		int        tol_v;

		ph_tol = '{31, 0, 1023, 0, 31};
		ph_req = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
		ph_len = '{200, 200, 200, 150, 250};

		add_row(end_row('0, '0, 1'b0, 1'b0));
		add_row(item_row(FN_START, 0, 0, 0, 0, mom4(MOM_MAX, MOM_MIN, 0, 1), 1'b0));
		add_row(item_row(FN_DAUGHTER, 0, 0, 0, 0, mom4(1, -1, 5, 0), 1'b0));
		add_row(end_row(mom4(MOM_MAX, MOM_MIN, 0, 1), mom4(MOM_MAX, MOM_MIN, 5, 1),
			1'b0, 1'b1));
		add_row(item_row(FN_ADD, -2, -8192, -3217, 0, '0, 1'b1));
		add_row(item_row(FN_ADD, 2, 8192, 3217, 8388607, '0, 1'b0));
		add_row(item_row(FN_ADD, 1, 0, 0, 1000, '0, 1'b0));
		add_row(item_row(FN_DAUGHTER, -2, -8161, -3186, 31,
			mom4(100, 200, 300, 400), 1'b0));
		add_row(item_row(FN_DAUGHTER, 2, 8160, 3217, 8388607, mom4(1, 2, 3, 4), 1'b0));
		add_row(item_row(FN_DAUGHTER, -1, 0, 0, 1000, mom4(-1, -2, -3, -4), 1'b0));
		// azimuth is compared without wrap
		add_row(item_row(FN_DAUGHTER, 2, 8192, -3217, 8388607,
			mom4(10, 10, 10, 10), 1'b0));
		add_row(item_row(FN_DAUGHTER, 1, 31, -31, 969,
			mom4(MOM_MAX, MOM_MAX, MOM_MAX, MOM_MAX), 1'b1));
		add_row(item_row(FN_END, 0, 0, 0, 0, '0, 1'b0));
		add_row(cfg_row(CFG_REQ, 1));
		add_row(item_row(FN_END, 0, 0, 0, 0, '0, 1'b0));
		add_row(item_row(FN_DAUGHTER, -2, -8192, -3217, 0, mom4(5, 5, 5, 5), 1'b0));
		add_row(item_row(FN_END, 0, 0, 0, 0, '0, 1'b0));
		add_row(cfg_row(CFG_REQ, 0));
		add_row(item_row(FN_DAUGHTER, 0, 100, 100, 100,
			mom4(MOM_MIN, MOM_MIN, MOM_MIN, MOM_MIN), 1'b0));
		add_row(item_row(FN_START, 0, 0, 0, 0, mom4(-5, 6, -7, 8), 1'b0));
		add_row(end_row(mom4(-5, 6, -7, 8), mom4(-5, 6, -7, 8), 1'b0, 1'b0));
		add_row(item_row(FN_START, 0, 0, 0, 0, '0, 1'b0));
		rw      = item_row(FN_ADD, 0, 0, 0, 0, '0, 1'b0);
		rw.reps = CJM_MAX_CONST + 1;
		add_row(rw);
		add_row(item_row(FN_DAUGHTER, 1, 0, 0, 0, mom4(7, 0, 0, 0), 1'b0));
		add_row(end_row('0, mom4(7, 0, 0, 0), 1'b0, 1'b1));
		add_row(cfg_row(CFG_TOL, 0));
		add_row(item_row(FN_DAUGHTER, 0, 1, 0, 0, mom4(1, 1, 1, 1), 1'b0));
		add_row(item_row(FN_DAUGHTER, 0, 0, 0, 0, mom4(9, 9, 9, 9), 1'b0));
		add_row(end_row('0, mom4(1, 1, 1, 1), 1'b0, 1'b1));
		add_row(cfg_row(CFG_TOL, 1023));
		add_row(item_row(FN_DAUGHTER, 0, 1023, -1023, 1023, mom4(2, 2, 2, 2), 1'b0));
		add_row(item_row(FN_DAUGHTER, 0, 1024, 0, 0, mom4(3, 3, 3, 3), 1'b0));
		add_row(end_row('0, mom4(3, 3, 3, 3), 1'b0, 1'b1));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				settle();
				write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
				cfg_we <= 1'b0;
			end else begin
				repeat (dir_rows[i].reps) begin
					transfer_item(dir_rows[i].it, got, r);
					if (dir_rows[i].has_want)
						cand_queue = {cand_queue, dir_rows[i].want};
					else if (got)
						cand_queue = {cand_queue, r};
				end
			end
		end

		for (int p = 0; p < 5; p++) begin
			settle();
			tol_v = (p == 3) ? $urandom_range(2, 1021) : ph_tol[p];
			write_reg(CFG_TOL, tol_v);
			write_reg(CFG_REQ, ph_req[p]);
			cfg_we <= 1'b0;
			quiet = (p == 0);
			run_jets(ph_len[p]);
		end

		quiet = 1'b0;
		settle();
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
